// File: src/dhks_pkg.sv
// ----------------------------------------------------------------------------
// dhks_pkg
// Shared types and constants for the double-hashed key set.
// ----------------------------------------------------------------------------
`default_nettype none

package dhks_pkg;

	localparam int KEY_W       = 64;
	localparam int LEN_W       = 4;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int SLOT_W      = 8;
	localparam int CFG_W       = 4;
	localparam int BYTE_W      = 8;
	localparam int KEY_MAX     = KEY_W / BYTE_W;
	localparam int MIN_LOG2    = 3;
	localparam int HASH_BASE   = 29;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic used;
		logic deleted;
	} dhks_flags_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [KEY_W-1:0] key;
	} dhks_entry_t;

	typedef struct packed {
		logic        key_we;
		logic        flag_we;
		dhks_entry_t entry;
		dhks_flags_t flags;
	} dhks_wr_t;

endpackage

`default_nettype wire

// File: src/dhks_hash.sv
// ----------------------------------------------------------------------------
// dhks_hash
// Horner hash of the key bytes, base 29, one byte per cycle from the last
// byte down to the first.
// ----------------------------------------------------------------------------
`default_nettype none

module dhks_hash import dhks_pkg::*; #(
	parameter int AW = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [LEN_W-1:0] len,
	output logic                  done,
	output logic [AW-1:0]         acc
);

	localparam int HW = (AW > BYTE_W) ? AW : BYTE_W;

	logic              busy_q;
	logic [LEN_W-1:0]  idx_q;
	logic [AW-1:0]     acc_q;
	logic [KEY_W-1:0]  key_q;
	logic [BYTE_W-1:0] cur_byte;
	logic [HW-1:0]     prod;

	always_comb begin
		cur_byte = '0;
		for (int i = 0; i < KEY_MAX; i++) begin
			if (idx_q == LEN_W'(i + 1)) begin
				cur_byte = key_q[i*BYTE_W +: BYTE_W];
			end
		end
	end

	assign prod = HW'(acc_q) * HW'(HASH_BASE) + HW'(cur_byte);
	assign done = busy_q && (idx_q == '0);
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			idx_q <= len;
			acc_q <= '0;
		end else if (busy_q && idx_q != '0) begin
			acc_q <= prod[AW-1:0];
			idx_q <= idx_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: src/dhks_table.sv
// ----------------------------------------------------------------------------
// dhks_table
// Slot storage: key memory and flag memory, one read and one write port
// each, with a clearing pass over the flags after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dhks_table import dhks_pkg::*; #(
	parameter int AW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	output logic               ready,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output dhks_entry_t        rd_entry,
	output dhks_flags_t        rd_flags,
	input  wire logic [AW-1:0] wr_addr,
	input  wire dhks_wr_t      wr
);

	localparam int DEPTH = 1 << AW;

	dhks_entry_t kmem [DEPTH];
	dhks_flags_t fmem [DEPTH];

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	assign ready = !clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			kmem[wr_addr] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry <= kmem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			fmem[clr_addr_q] <= '0;
		end else if (wr.flag_we) begin
			fmem[wr_addr] <= wr.flags;
		end
		if (rd_en) begin
			rd_flags <= fmem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: src/double_hash_key_set_core.sv
// ----------------------------------------------------------------------------
// double_hash_key_set_core
// Set of short byte-string keys in an open-addressed, double-hashed table.
//
// Requests enter on s_axis (command, key, key length); each gives one
// response on m_axis (status, slot). cfg_we/cfg_wdata set log2 of the
// number of slots in use; the user must write them only while the block
// is idle, since the block itself does not enforce this. After acceptance
// a request's key is hashed, then one slot is probed per table read (one
// table read per cycle, up to the table size), and then the request
// finishes; an unknown command goes straight to the finish. One request
// is worked on at a time; the next is accepted once the previous response
// has been loaded into the output register.
// After reset the flag memory is cleared, one slot per cycle, over all
// 2^LOG2_SLOTS slots, and s_axis_tready stays low until it is done.
// If m_axis_tready is low the response waits in the output register and
// the block stops with the following response ready until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_key_set_core import dhks_pkg::*; #(
	parameter int LOG2_SLOTS = 8,
	parameter int KEY_BYTES  = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_W-1:0]       cfg_wdata,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// cmd[1:0], key[65:2], key_len[69:66], zero[71:70]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// status[1:0], slot[9:2], zero[15:10]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int AW   = LOG2_SLOTS;
	localparam int SUMW = ((AW > LEN_W) ? AW : LEN_W) + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_HASH  = 2'd1;
	localparam logic [1:0] ST_PROBE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]          state_q;
	logic [CFG_W-1:0]    size_log2_q;
	logic [CFG_W-1:0]    cur_log2;
	logic [AW-1:0]       mask;

	logic [CMD_W-1:0]    in_cmd;
	logic [KEY_W-1:0]    in_key;
	logic [LEN_W-1:0]    in_len;
	logic [LEN_W-1:0]    in_len_c;
	logic [KEY_W-1:0]    in_key_m;
	logic                in_accept;
	logic                cmd_known;

	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    step_raw;
	logic [LEN_W-1:0]    step;

	logic                hash_done;
	logic [AW-1:0]       hash_acc;
	logic [AW-1:0]       first;

	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       next_addr;
	logic [AW-1:0]       probe_cnt_q;
	logic                have_tomb_q;
	logic [AW-1:0]       tomb_q;

	logic                tbl_ready;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	dhks_entry_t         rd_entry;
	dhks_flags_t         rd_flags;
	logic [AW-1:0]       wr_addr;
	dhks_wr_t            wr;

	logic                hit;
	logic                last;
	logic                fin;
	logic                tomb_set;
	logic [STATUS_W-1:0] res_status;
	logic [AW-1:0]       res_where;
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;

	logic                out_valid_q;
	logic                out_load;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;

	// table geometry
	always_comb begin
		if (size_log2_q < CFG_W'(MIN_LOG2)) begin
			cur_log2 = CFG_W'(MIN_LOG2);
		end else if (int'(size_log2_q) > LOG2_SLOTS) begin
			cur_log2 = CFG_W'(LOG2_SLOTS);
		end else begin
			cur_log2 = size_log2_q;
		end
	end

	always_comb begin
		for (int i = 0; i < AW; i++) begin
			mask[i] = (i < int'(cur_log2));
		end
	end

	// request unpacking
	assign in_cmd    = s_axis_tdata[1:0];
	assign in_key    = s_axis_tdata[65:2];
	assign in_len    = s_axis_tdata[69:66];
	assign in_len_c  = (int'(in_len) > KEY_BYTES) ? LEN_W'(KEY_BYTES) : in_len;
	assign cmd_known = (in_cmd == CMD_INSERT) || (in_cmd == CMD_DELETE) ||
	                   (in_cmd == CMD_SEARCH);

	always_comb begin
		for (int i = 0; i < KEY_MAX; i++) begin
			in_key_m[i*BYTE_W +: BYTE_W] = (i < int'(in_len_c)) ?
				in_key[i*BYTE_W +: BYTE_W] : '0;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE) && tbl_ready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	dhks_hash #(
		.AW (AW)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept && cmd_known),
		.key    (in_key_m),
		.len    (in_len_c),
		.done   (hash_done),
		.acc    (hash_acc)
	);

	assign first = hash_acc & mask;

	// probe step, odd so that every slot is reached
	always_comb begin
		step_raw = len_q;
		if (cur_log2 == CFG_W'(MIN_LOG2)) begin
			if (len_q == LEN_W'(7)) begin
				step_raw = '0;
			end else if (len_q == LEN_W'(8)) begin
				step_raw = LEN_W'(1);
			end
		end
		step = step_raw[0] ? step_raw : step_raw + 1'b1;
	end

	assign next_addr = AW'(SUMW'(addr_q) + SUMW'(step)) & mask;
	assign rd_en     = ((state_q == ST_HASH) && hash_done) || (state_q == ST_PROBE);
	assign rd_addr   = (state_q == ST_HASH) ? first : next_addr;

	dhks_table #(
		.AW (AW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ready    (tbl_ready),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.rd_flags (rd_flags),
		.wr_addr  (wr_addr),
		.wr       (wr)
	);

	// probe evaluation
	assign hit  = rd_flags.used && !rd_flags.deleted &&
	              (rd_entry.len == len_q) && (rd_entry.key == key_q);
	assign last = (probe_cnt_q == mask);

	always_comb begin
		fin        = 1'b0;
		tomb_set   = 1'b0;
		res_status = STATUS_FAIL;
		res_where  = addr_q;
		wr_addr    = addr_q;
		wr         = '0;
		wr.entry   = '{len: len_q, key: key_q};
		wr.flags   = '{used: 1'b1, deleted: 1'b0};
		if (state_q == ST_PROBE) begin
			if (!rd_flags.used) begin
				fin = 1'b1;
				if (cmd_q == CMD_INSERT) begin
					res_status = STATUS_OK;
					res_where  = have_tomb_q ? tomb_q : addr_q;
					wr_addr    = res_where;
					wr.key_we  = 1'b1;
					wr.flag_we = 1'b1;
				end
			end else if (rd_flags.deleted) begin
				tomb_set = (cmd_q == CMD_INSERT) && !have_tomb_q;
			end else if (hit) begin
				fin = 1'b1;
				if (cmd_q != CMD_INSERT) begin
					res_status = STATUS_OK;
					if (cmd_q == CMD_DELETE) begin
						wr.flag_we = 1'b1;
						wr.flags   = '{used: 1'b1, deleted: 1'b1};
					end
				end
			end
			if (!fin && last) begin
				fin = 1'b1;
				if (cmd_q == CMD_INSERT) begin
					if (have_tomb_q || tomb_set) begin
						res_status = STATUS_OK;
						res_where  = have_tomb_q ? tomb_q : addr_q;
						wr_addr    = res_where;
						wr.key_we  = 1'b1;
						wr.flag_we = 1'b1;
					end else begin
						res_status = STATUS_FULL;
					end
				end
			end
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_log2_q <= CFG_W'(MIN_LOG2);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_log2_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= cmd_known ? ST_HASH : ST_DONE;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (fin) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q        <= in_cmd;
			key_q        <= in_key_m;
			len_q        <= in_len_c;
			res_status_q <= STATUS_FAIL;
			res_slot_q   <= '0;
		end
		if (state_q == ST_HASH && hash_done) begin
			addr_q      <= first;
			probe_cnt_q <= '0;
			have_tomb_q <= 1'b0;
		end
		if (state_q == ST_PROBE) begin
			if (fin) begin
				res_status_q <= res_status;
				res_slot_q   <= (res_status == STATUS_OK) ? SLOT_W'(res_where) : '0;
			end else begin
				addr_q      <= next_addr;
				probe_cnt_q <= probe_cnt_q + 1'b1;
				if (tomb_set) begin
					have_tomb_q <= 1'b1;
					tomb_q      <= addr_q;
				end
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - SLOT_W - STATUS_W){1'b0}}, out_slot_q, out_status_q};

endmodule

`default_nettype wire

// File: tb/double_hash_key_set_core_checker.sv
// ----------------------------------------------------------------------------
// double_hash_key_set_core_checker
// Watches the request, response and configuration ports of the key set core.
// For every accepted request it works out the status and slot that the block
// must answer, using a private copy of the hash table and of the table size,
// and then matches each accepted response, in order, field by field.
// Mismatches, stray responses and the number still awaited go to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_hash_key_set_core_checker import dhks_pkg::*; #(
	parameter int LOG2_SLOTS = 8,
	parameter int KEY_BYTES  = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// cmd[1:0], key[65:2], key_len[69:66], zero[71:70]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// status[1:0], slot[9:2], zero[15:10]
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output int                     fail_count,
	output int                     outstanding
);

	localparam int NSLOTS = 1 << LOG2_SLOTS;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [KEY_W-1:0] key;
		logic [CMD_W-1:0] cmd;
	} key_request_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] status;
	} set_response_t;

	localparam int REQ_W  = $bits(key_request_t);
	localparam int RESP_W = $bits(set_response_t);

	logic [CFG_W-1:0] table_log2;
	logic [KEY_W-1:0] stored_key [NSLOTS];
	logic [LEN_W-1:0] stored_len [NSLOTS];
	logic             slot_used [NSLOTS];
	logic             slot_deleted [NSLOTS];
	set_response_t    expected_responses [$];

	function automatic set_response_t predict_set_op(input key_request_t req);
		int unsigned lg, size, mask, len, first, mult, stride, h, tomb, free_at, where;
		logic [KEY_W-1:0] k;
		logic dup, have_tomb, have_free, found;
		set_response_t r;
		lg = table_log2;
		if (lg < MIN_LOG2) lg = MIN_LOG2;
		if (lg > LOG2_SLOTS) lg = LOG2_SLOTS;
		size = 1 << lg;
		mask = size - 1;
		len = (req.len > KEY_BYTES) ? KEY_BYTES : req.len;
		k = (len >= KEY_MAX) ? req.key : req.key & ((64'd1 << (BYTE_W * len)) - 64'd1);
		first = 0;
		mult = 1;
		for (int i = 0; i < len; i++) begin
			first = (first + k[BYTE_W*i +: BYTE_W] * mult) & mask;
			mult = (mult * HASH_BASE) & mask;
		end
		// odd stride so that every slot is visited
		stride = len % (size - 1);
		if (stride % 2 == 0) stride = stride + 1;
		r.status = STATUS_FAIL;
		r.slot = '0;
		where = 0;
		h = first;
		dup = 1'b0;
		have_tomb = 1'b0;
		have_free = 1'b0;
		found = 1'b0;
		tomb = 0;
		free_at = 0;
		case (req.cmd)
			CMD_INSERT: begin
				for (int i = 0; i < size; i++) begin
					if (!slot_used[h]) begin
						have_free = 1'b1;
						free_at = h;
						break;
					end
					if (slot_deleted[h]) begin
						if (!have_tomb) begin
							have_tomb = 1'b1;
							tomb = h;
						end
					end else if (stored_len[h] == len && stored_key[h] == k) begin
						dup = 1'b1;
						break;
					end
					h = (h + stride) & mask;
				end
				if (dup) begin
					r.status = STATUS_FAIL;
				end else if (have_tomb || have_free) begin
					where = have_tomb ? tomb : free_at;
					stored_key[where] = k;
					stored_len[where] = len;
					slot_used[where] = 1'b1;
					slot_deleted[where] = 1'b0;
					r.status = STATUS_OK;
				end else begin
					r.status = STATUS_FULL;
				end
			end
			CMD_DELETE, CMD_SEARCH: begin
				for (int i = 0; i < size; i++) begin
					if (!slot_used[h]) break;
					if (!slot_deleted[h] && stored_len[h] == len && stored_key[h] == k) begin
						found = 1'b1;
						where = h;
						break;
					end
					h = (h + stride) & mask;
				end
				if (found) begin
					r.status = STATUS_OK;
					if (req.cmd == CMD_DELETE) slot_deleted[where] = 1'b1;
				end
			end
			default: ;
		endcase
		if (r.status == STATUS_OK) r.slot = where[SLOT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		set_response_t want, got;
		if (!arst_n) begin
			table_log2 = CFG_W'(MIN_LOG2);
			for (int i = 0; i < NSLOTS; i++) begin
				slot_used[i] = 1'b0;
				slot_deleted[i] = 1'b0;
			end
			expected_responses.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) table_log2 = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				expected_responses.push_back(
					predict_set_op(key_request_t'(s_axis_tdata[REQ_W-1:0])));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = set_response_t'(m_axis_tdata[RESP_W-1:0]);
				if (expected_responses.size() == 0) begin
					$display("%0t: response with none awaited: expected none actual status %0d slot %0d",
						$time, got.status, got.slot);
					fail_count++;
				end else begin
					want = expected_responses.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, want.status, got.status);
						fail_count++;
					end
					if (got.slot !== want.slot) begin
						$display("%0t: slot mismatch: expected %0d actual %0d",
							$time, want.slot, got.slot);
						fail_count++;
					end
				end
			end
			outstanding <= expected_responses.size();
		end
	end

endmodule

// File: tb/double_hash_key_set_core_tb.sv
// ----------------------------------------------------------------------------
// double_hash_key_set_core_tb
// Drives insert, delete, search and unknown requests into the key set core:
// first a directed run on the smallest table (empty keys, long and garbage
// padded keys, duplicates, a full table), then random phases over several
// table sizes with keys drawn mostly from a small pool so that hits, misses,
// tombstones and full tables occur. Both handshakes idle at random per phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_hash_key_set_core_tb;
	import dhks_pkg::*;

	localparam int LOG2_SLOTS   = 8;
	localparam int KEY_BYTES    = 8;
	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASES       = 6;
	localparam int POOL_MAX     = 256;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	int phase_size [PHASES]  = '{15, 4, 8, 0, 5, 9};
	int phase_send [PHASES]  = '{0, 73, 0, 21, 0, 73};
	int phase_recv [PHASES]  = '{0, 0, 73, 21, 0, 0};
	int phase_items [PHASES] = '{170, 150, 190, 130, 140, 150};
	int phase_pool [PHASES]  = '{40, 24, 220, 12, 48, 160};

	logic [KEY_W-1:0] pool_key [POOL_MAX];
	logic [LEN_W-1:0] pool_len [POOL_MAX];
	int               pool_n;

	double_hash_key_set_core #(
		.LOG2_SLOTS(LOG2_SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	double_hash_key_set_core_checker #(
		.LOG2_SLOTS(LOG2_SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// valid stays high between back-to-back requests; the caller lowers it
	task automatic send_set_request(input logic [CMD_W-1:0] cmd,
		input logic [KEY_W-1:0] key, input logic [LEN_W-1:0] len);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, len, key, cmd};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_table_size(input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic refill_key_pool(input int n);
		pool_n = n;
		for (int i = 0; i < n; i++) begin
			pool_key[i] = {$urandom, $urandom};
			case ($urandom_range(9))
				0: pool_len[i] = 4'd0;
				1: pool_len[i] = LEN_W'($urandom_range(9, 15));
				default: pool_len[i] = LEN_W'($urandom_range(1, 8));
			endcase
		end
	endtask

	task automatic send_random_request();
		int p, roll;
		logic [KEY_W-1:0] key, low_mask;
		logic [LEN_W-1:0] len;
		logic [CMD_W-1:0] cmd;
		if ($urandom_range(99) < 85) begin
			p = $urandom_range(pool_n - 1);
			len = pool_len[p];
			// junk above the key length must not matter
			low_mask = (len >= KEY_MAX) ? '1 : (64'd1 << (BYTE_W * len)) - 64'd1;
			key = (pool_key[p] & low_mask) | ({$urandom, $urandom} & ~low_mask);
			roll = $urandom_range(99);
			if (roll < 45) cmd = CMD_INSERT;
			else if (roll < 70) cmd = CMD_DELETE;
			else if (roll < 96) cmd = CMD_SEARCH;
			else cmd = CMD_UNKNOWN;
		end else begin
			cmd = CMD_W'($urandom_range(3));
			key = {$urandom, $urandom};
			len = LEN_W'($urandom_range(15));
		end
		send_set_request(cmd, key, len);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		// flag memory clearing holds tready low
		do @(posedge clk); while (!s_axis_tready);
		write_table_size(CFG_W'(MIN_LOG2));

		send_set_request(CMD_SEARCH, 64'h0123_4567_89AB_CDEF, 4'd0);
		send_set_request(CMD_INSERT, 64'h0123_4567_89AB_CDEF, 4'd0);
		send_set_request(CMD_INSERT, '1, 4'd0);
		send_set_request(CMD_INSERT, '1, 4'd8);
		send_set_request(CMD_INSERT, '1, 4'd15);
		send_set_request(CMD_SEARCH, 64'hA5A5_A5A5_A5A5_A5A5, 4'd3);
		send_set_request(CMD_UNKNOWN, '1, 4'd8);
		send_set_request(CMD_DELETE, 64'hFEED_0000_1111_2222, 4'd0);
		// fill the small table until it reports full
		for (int j = 1; j <= 9; j++)
			send_set_request(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF00 | KEY_W'(j), 4'd1);
		send_set_request(CMD_SEARCH, 64'h77, 4'd1);
		send_set_request(CMD_INSERT, 64'h77, 4'd1);
		send_set_request(CMD_DELETE, 64'h03, 4'd1);
		send_set_request(CMD_INSERT, 64'h55, 4'd1);
		send_set_request(CMD_SEARCH, 64'h55, 4'd1);
		send_set_request(CMD_SEARCH, 64'h03, 4'd1);
		send_set_request(CMD_DELETE, '1, 4'd12);
		send_set_request(CMD_INSERT, '0, 4'd12);
		send_set_request(CMD_SEARCH, '0, 4'd8);
		wait_until_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_table_size(CFG_W'(phase_size[ph]));
			sender_idle_pct = phase_send[ph];
			receiver_stall_pct = phase_recv[ph];
			refill_key_pool(phase_pool[ph]);
			repeat (phase_items[ph]) send_random_request();
			wait_until_drained();
		end

		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
